[src/wtssq_pkg.sv]
// Shared types, register codes, scale tables and pipeline constants for the semitone quantizer.
package wtssq_pkg;

  // Configuration register indexes.
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_SCALE_MODE   = 2'd0;
  localparam cfg_index_t REG_STEP_RADIUS  = 2'd1;
  localparam cfg_index_t REG_WIDTH_CENTER = 2'd2;
  localparam cfg_index_t REG_WIDTH_SPAN   = 2'd3;

  // Scale mode codes; the two unused codes behave as chromatic.
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_CHROMATIC  = 3'd0;
  localparam mode_t MODE_MAJOR      = 3'd1;
  localparam mode_t MODE_MAJOR_PENT = 3'd2;
  localparam mode_t MODE_MINOR      = 3'd3;
  localparam mode_t MODE_MINOR_PENT = 3'd4;
  localparam mode_t MODE_BLUES      = 3'd5;

  // Register reset values.
  localparam mode_t      RST_SCALE_MODE = MODE_CHROMATIC;
  localparam logic [6:0] RST_RADIUS     = 7'd12;
  localparam int         RST_CENTER     = 17203;
  localparam int         RST_SPAN       = 31130;

  // Chromatic step count: 13 magnitude bits, 14 bits signed after the floor fix.
  localparam int QBITS       = 13;
  localparam int C_BITS      = QBITS + 1;
  localparam int C_MAX       = 8191;
  localparam int C_MIN       = -8192;
  localparam int DIV_STEPS   = 2;
  localparam int DIV_STAGES  = (QBITS + DIV_STEPS - 1) / DIV_STEPS;

  // Octave split: the step count is biased by a common multiple of 5, 6 and 7
  // so that the split works on a non-negative value.
  localparam int OFFSET      = 8400;
  localparam int U_BITS      = 15;
  localparam int RECIP_BITS  = 15;
  localparam int RECIP_SHIFT = 17;
  localparam int DEG_BITS    = 3;
  localparam int NOTE_BITS   = 4;
  localparam int BIAS_BITS   = 15;

  // Result before saturation and the saturated output range.
  localparam int R_BITS      = 18;
  localparam int SEMI_BITS   = 12;
  localparam int SEMI_MAX    = 2047;
  localparam int SEMI_MIN    = -2048;
  localparam logic signed [SEMI_BITS-1:0] SEMI_HI = 12'sh7FF;
  localparam logic signed [SEMI_BITS-1:0] SEMI_LO = 12'sh800;

  // True for the five scale modes.
  function automatic logic scale_used(mode_t m);
    logic used;
    unique case (m)
      MODE_MAJOR, MODE_MAJOR_PENT, MODE_MINOR,
      MODE_MINOR_PENT, MODE_BLUES: used = 1'b1;
      default:                      used = 1'b0;
    endcase
    return used;
  endfunction

  // Notes per octave of each scale.
  function automatic logic [2:0] scale_len(mode_t m);
    logic [2:0] len;
    unique case (m)
      MODE_MAJOR, MODE_MINOR:           len = 3'd7;
      MODE_MAJOR_PENT, MODE_MINOR_PENT: len = 3'd5;
      MODE_BLUES:                       len = 3'd6;
      default:                          len = 3'd1;
    endcase
    return len;
  endfunction

  // floor(2^RECIP_SHIFT / len), exact to within one after the shift.
  function automatic logic [RECIP_BITS-1:0] scale_recip(mode_t m);
    logic [RECIP_BITS-1:0] rc;
    unique case (m)
      MODE_MAJOR, MODE_MINOR:           rc = 15'd18724;
      MODE_MAJOR_PENT, MODE_MINOR_PENT: rc = 15'd26214;
      MODE_BLUES:                       rc = 15'd21845;
      default:                          rc = '0;
    endcase
    return rc;
  endfunction

  // 12 * OFFSET / len: removes the octave bias after the split.
  function automatic logic [BIAS_BITS-1:0] scale_bias(mode_t m);
    logic [BIAS_BITS-1:0] b;
    unique case (m)
      MODE_MAJOR, MODE_MINOR:           b = 15'd14400;
      MODE_MAJOR_PENT, MODE_MINOR_PENT: b = 15'd20160;
      MODE_BLUES:                       b = 15'd16800;
      default:                          b = '0;
    endcase
    return b;
  endfunction

  // Semitone of each scale degree within the octave.
  function automatic logic [NOTE_BITS-1:0] scale_note(mode_t m, logic [DEG_BITS-1:0] deg);
    logic [NOTE_BITS-1:0] n;
    n = '0;
    unique case (m)
      MODE_MAJOR: begin
        unique case (deg)
          3'd1:    n = 4'd2;
          3'd2:    n = 4'd4;
          3'd3:    n = 4'd5;
          3'd4:    n = 4'd7;
          3'd5:    n = 4'd9;
          3'd6:    n = 4'd11;
          default: n = 4'd0;
        endcase
      end
      MODE_MAJOR_PENT: begin
        unique case (deg)
          3'd1:    n = 4'd2;
          3'd2:    n = 4'd4;
          3'd3:    n = 4'd7;
          3'd4:    n = 4'd9;
          default: n = 4'd0;
        endcase
      end
      MODE_MINOR: begin
        unique case (deg)
          3'd1:    n = 4'd2;
          3'd2:    n = 4'd3;
          3'd3:    n = 4'd5;
          3'd4:    n = 4'd7;
          3'd5:    n = 4'd8;
          3'd6:    n = 4'd10;
          default: n = 4'd0;
        endcase
      end
      MODE_MINOR_PENT: begin
        unique case (deg)
          3'd1:    n = 4'd3;
          3'd2:    n = 4'd5;
          3'd3:    n = 4'd7;
          3'd4:    n = 4'd10;
          default: n = 4'd0;
        endcase
      end
      MODE_BLUES: begin
        unique case (deg)
          3'd1:    n = 4'd3;
          3'd2:    n = 4'd5;
          3'd3:    n = 4'd6;
          3'd4:    n = 4'd7;
          3'd5:    n = 4'd10;
          default: n = 4'd0;
        endcase
      end
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

[src/width_to_scale_semitone_quantizer.sv]
// Pipelined mapping of a line width to a scale-quantized semitone offset.
// Pipeline depth: 15 register stages, the last of them the output register.
// Throughput: one item per cycle while the output is not stalled; depth is set by the
// restoring divider, which resolves up to two quotient bits per stage over seven stages.
// A stalled output holds its result while bubbles further up still fill.
// Reset clears all stage valid bits and loads the register defaults.
module width_to_scale_semitone_quantizer
  import wtssq_pkg::*;
#(
  parameter int WIDTH_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  cfg_index_t                  cfg_index,
  input  logic [WIDTH_BITS-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [WIDTH_BITS-1:0]       stroke_width,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SEMI_BITS-1:0] semitone,
  output logic                        clamped
);

  localparam int PW      = WIDTH_BITS + 10;
  localparam int MW      = WIDTH_BITS + 9;
  localparam int RW      = WIDTH_BITS + QBITS;
  localparam int PR_BITS = U_BITS + RECIP_BITS;
  localparam int QE_BITS = PR_BITS - RECIP_SHIFT;
  localparam int ST_DIV  = 3;
  localparam int ST_C    = ST_DIV + DIV_STAGES;
  localparam int ST_U    = ST_C + 1;
  localparam int ST_MUL  = ST_U + 1;
  localparam int ST_CORR = ST_MUL + 1;
  localparam int ST_OUT  = ST_CORR + 1;
  localparam int NS      = ST_OUT + 1;

  localparam logic signed [R_BITS-1:0] R_MAX = R_BITS'(SEMI_MAX);
  localparam logic signed [R_BITS-1:0] R_MIN = R_BITS'(SEMI_MIN);

  // Configuration registers.
  mode_t                 scale_mode;
  logic [6:0]            step_radius;
  logic [WIDTH_BITS-1:0] width_center;
  logic [WIDTH_BITS-1:0] width_span;
  logic [WIDTH_BITS-1:0] span_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode   <= RST_SCALE_MODE;
      step_radius  <= RST_RADIUS;
      width_center <= WIDTH_BITS'(RST_CENTER);
      width_span   <= WIDTH_BITS'(RST_SPAN);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCALE_MODE:   scale_mode   <= cfg_data[2:0];
        REG_STEP_RADIUS:  step_radius  <= cfg_data[6:0];
        REG_WIDTH_CENTER: width_center <= cfg_data;
        REG_WIDTH_SPAN:   width_span   <= cfg_data;
      endcase
    end
  end

  // A zero span divides as a span of one.
  assign span_eff = (width_span == '0) ? WIDTH_BITS'(1) : width_span;

  // Stage valid bits and per-stage advance; a stage loads when it is empty or
  // the stage below it moves on.
  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[ST_OUT];

  // Stage 0: (center - width) * 2 * radius.
  logic signed [WIDTH_BITS:0] diff;
  logic signed [8:0]          rad2;
  logic signed [PW-1:0]       p0_prod;

  assign diff = $signed({1'b0, width_center}) - $signed({1'b0, stroke_width});
  assign rad2 = $signed({1'b0, step_radius, 1'b0});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0_prod <= diff * rad2;
    end
  end

  // Stage 1: sign and magnitude of the numerator.
  logic          p1_neg;
  logic [MW-1:0] p1_mag;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p1_neg <= p0_prod[PW-1];
      p1_mag <= p0_prod[PW-1] ? MW'(-p0_prod) : MW'(p0_prod);
    end
  end

  // Divider state; entry 0 is loaded by stage 2, entry j+1 by divider stage j.
  logic [RW-1:0]    d_rem [DIV_STAGES+1];
  logic [QBITS-1:0] d_q   [DIV_STAGES+1];
  logic             d_neg [DIV_STAGES+1];
  logic             d_ovf [DIV_STAGES+1];

  // Stage 2: a quotient that needs more than QBITS bits saturates every mode.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d_rem[0] <= RW'(p1_mag);
      d_q[0]   <= '0;
      d_neg[0] <= p1_neg;
      d_ovf[0] <= RW'(p1_mag) >= (RW'(span_eff) << QBITS);
    end
  end

  // Restoring division, up to DIV_STEPS quotient bits per stage, most significant first.
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [RW-1:0]    rem_step;
    logic [QBITS-1:0] q_step;

    always_comb begin
      rem_step = d_rem[j];
      q_step   = d_q[j];
      for (int t = 0; t < DIV_STEPS; t++) begin
        if (j * DIV_STEPS + t < QBITS) begin
          if (rem_step >= (RW'(span_eff) << (QBITS - 1 - (j * DIV_STEPS + t)))) begin
            rem_step = rem_step - (RW'(span_eff) << (QBITS - 1 - (j * DIV_STEPS + t)));
            q_step[QBITS - 1 - (j * DIV_STEPS + t)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[ST_DIV + j]) begin
        d_rem[j+1] <= rem_step;
        d_q[j+1]   <= q_step;
        d_neg[j+1] <= d_neg[j];
        d_ovf[j+1] <= d_ovf[j];
      end
    end
  end

  // Floor fix for negative numerators, and saturation of the step count.
  logic signed [C_BITS-1:0] c_next;
  logic signed [C_BITS-1:0] pc_c;

  always_comb begin
    priority if (d_ovf[DIV_STAGES]) begin
      c_next = d_neg[DIV_STAGES] ? C_BITS'(C_MIN) : C_BITS'(C_MAX);
    end else if (d_neg[DIV_STAGES]) begin
      c_next = -$signed({1'b0, d_q[DIV_STAGES]}) -
               $signed(C_BITS'(d_rem[DIV_STAGES] != '0));
    end else begin
      c_next = $signed({1'b0, d_q[DIV_STAGES]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_C]) begin
      pc_c <= c_next;
    end
  end

  // Bias the step count to a non-negative value for the octave split.
  logic [U_BITS-1:0]        pu_u;
  logic signed [C_BITS-1:0] pu_c;

  always_ff @(posedge clk) begin
    if (adv[ST_U]) begin
      pu_u <= {pc_c[C_BITS-1], pc_c} + U_BITS'(OFFSET);
      pu_c <= pc_c;
    end
  end

  // Reciprocal multiply for the octave estimate.
  logic [PR_BITS-1:0]       pm_prod;
  logic [U_BITS-1:0]        pm_u;
  logic signed [C_BITS-1:0] pm_c;

  always_ff @(posedge clk) begin
    if (adv[ST_MUL]) begin
      pm_prod <= pu_u * scale_recip(scale_mode);
      pm_u    <= pu_u;
      pm_c    <= pu_c;
    end
  end

  // The estimate is low by at most one: one compare and subtract corrects it.
  logic [QE_BITS-1:0]       qe;
  logic [2:0]               len;
  logic [U_BITS-1:0]        rem2;
  logic [QE_BITS-1:0]       q_next;
  logic [DEG_BITS-1:0]      deg_next;
  logic [QE_BITS-1:0]       pr_q;
  logic [DEG_BITS-1:0]      pr_deg;
  logic signed [C_BITS-1:0] pr_c;

  always_comb begin
    qe   = pm_prod[PR_BITS-1:RECIP_SHIFT];
    len  = scale_len(scale_mode);
    rem2 = pm_u - U_BITS'(U_BITS'(qe) * U_BITS'(len));
    if (rem2 >= U_BITS'(len)) begin
      q_next   = qe + QE_BITS'(1);
      deg_next = DEG_BITS'(rem2 - U_BITS'(len));
    end else begin
      q_next   = qe;
      deg_next = DEG_BITS'(rem2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_CORR]) begin
      pr_q   <= q_next;
      pr_deg <= deg_next;
      pr_c   <= pm_c;
    end
  end

  // Octave * 12 plus the scale note, then saturation to the output range.
  logic [R_BITS-1:0]        r_scale;
  logic signed [R_BITS-1:0] r;

  always_comb begin
    r_scale = R_BITS'({pr_q, 3'b000}) + R_BITS'({pr_q, 2'b00}) +
              R_BITS'(scale_note(scale_mode, pr_deg)) - R_BITS'(scale_bias(scale_mode));
    r = scale_used(scale_mode) ? $signed(r_scale) : R_BITS'(pr_c);
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      priority if (r > R_MAX) begin
        semitone <= SEMI_HI;
        clamped  <= 1'b1;
      end else if (r < R_MIN) begin
        semitone <= SEMI_LO;
        clamped  <= 1'b1;
      end else begin
        semitone <= $signed(r[SEMI_BITS-1:0]);
        clamped  <= 1'b0;
      end
    end
  end

  // A transfer at the input always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted input did not enter the first stage");

  // Input back-pressure only when every stage is full and the output stalls.
  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v) && !out_ready)
    else $error("input stalled with room in the pipeline");

  // Without overflow the divider remainder ends below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    v[ST_C-1] && !d_ovf[DIV_STAGES] |-> d_rem[DIV_STAGES] < RW'(span_eff))
    else $error("divider remainder not below the span");

  // The corrected degree stays inside the scale.
  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    v[ST_CORR] && scale_used(scale_mode) |-> pr_deg < scale_len(scale_mode))
    else $error("scale degree out of range");

  // A clamped result sits on one of the range limits.
  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |-> semitone == SEMI_HI || semitone == SEMI_LO)
    else $error("clamped result not at a range limit");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the width-to-scale semitone quantizer.
module tb_top
  import wtssq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W_BITS          = 16;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 30;
  localparam int unsigned LIMIT  = 300000;

  // Mode codes the block treats as chromatic.
  localparam mode_t MODE_SPARE_6 = 3'd6;
  localparam mode_t MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [SEMI_BITS-1:0] semi;
    logic                        clamp;
  } note_t;

  // One directed transfer with the register settings it runs under.
  typedef struct packed {
    mode_t                       mode;
    logic [6:0]                  radius;
    logic [W_BITS-1:0]           center;
    logic [W_BITS-1:0]           span;
    logic [W_BITS-1:0]           width;
    logic                        known;
    logic signed [SEMI_BITS-1:0] semi;
    logic                        clamp;
  } stim_row_t;

  // With radius 64, center 32768 and span 16384 the step count is (32768 - width) / 128.
  localparam stim_row_t DIRECTED [23] = '{
    '{MODE_CHROMATIC,   12, 17203, 31130, 17203, 1,     0, 0},
    '{MODE_CHROMATIC,   12, 17203, 31130,     0, 1,    13, 0},
    '{MODE_CHROMATIC,   12, 17203, 31130, 65535, 1,   -38, 0},
    '{MODE_CHROMATIC,  127, 65535,     1,     0, 1,  2047, 1},
    '{MODE_CHROMATIC,  127,     0,     1, 65535, 1, -2048, 1},
    '{MODE_CHROMATIC,    1, 32768,     0, 32767, 1,     2, 0},
    '{MODE_MAJOR,        0, 17203, 31130,     0, 1,     0, 0},
    '{MODE_MAJOR,        0, 17203, 31130, 65535, 1,     0, 0},
    '{MODE_SPARE_6,     12, 17203, 31130,     0, 1,    13, 0},
    '{MODE_SPARE_7,     12, 17203, 31130, 65535, 1,   -38, 0},
    '{MODE_MAJOR,       64, 32768, 16384, 32769, 0,     0, 0},
    '{MODE_MAJOR,       64, 32768, 16384, 31104, 0,     0, 0},
    '{MODE_MAJOR,       64, 32768, 16384, 33664, 0,     0, 0},
    '{MODE_MAJOR_PENT,  64, 32768, 16384, 33536, 0,     0, 0},
    '{MODE_MAJOR_PENT,  64, 32768, 16384, 32256, 0,     0, 0},
    '{MODE_MINOR,       64, 32768, 16384, 33792, 0,     0, 0},
    '{MODE_MINOR,       64, 32768, 16384, 32000, 0,     0, 0},
    '{MODE_MINOR_PENT,  64, 32768, 16384, 33152, 0,     0, 0},
    '{MODE_MINOR_PENT,  64, 32768, 16384, 31616, 0,     0, 0},
    '{MODE_BLUES,       64, 32768, 16384, 33664, 0,     0, 0},
    '{MODE_BLUES,       64, 32768, 16384, 32128, 0,     0, 0},
    '{MODE_BLUES,      127, 65535,     1,     0, 1,  2047, 1},
    '{MODE_MINOR,      127,     0,     1, 65535, 1, -2048, 1}
  };

  // Semitones of each scale degree, row by mode code; row zero is unused.
  int scale_steps [6][7] = '{
    '{0, 0, 0, 0, 0, 0,  0},
    '{0, 2, 4, 5, 7, 9, 11},
    '{0, 2, 4, 7, 9, 0,  0},
    '{0, 2, 3, 5, 7, 8, 10},
    '{0, 3, 5, 7, 10, 0, 0},
    '{0, 3, 5, 6, 7, 10, 0}
  };
  int scale_size [6] = '{1, 7, 5, 7, 5, 6};

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_wr_en    = 1'b0;
  cfg_index_t        cfg_index    = REG_SCALE_MODE;
  logic [W_BITS-1:0] cfg_data     = '0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [W_BITS-1:0] stroke_width = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic signed [SEMI_BITS-1:0] semitone;
  logic              clamped;

  // Register copies used for prediction.
  mode_t             cur_mode   = RST_SCALE_MODE;
  logic [6:0]        cur_radius = RST_RADIUS;
  logic [W_BITS-1:0] cur_center = W_BITS'(RST_CENTER);
  logic [W_BITS-1:0] cur_span   = W_BITS'(RST_SPAN);

  note_t       expected_notes [$];
  int          mismatches    = 0;
  int          burst_left    = 0;
  bit          sender_steady = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned cycle_count   = 0;

  width_to_scale_semitone_quantizer #(.WIDTH_BITS(W_BITS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .stroke_width (stroke_width),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .semitone     (semitone),
    .clamped      (clamped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Quotient rounded toward minus infinity.
  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Expected semitone and saturation flag for a width under the current registers.
  function automatic note_t quantize_width(logic [W_BITS-1:0] w);
    longint den, diff, rad, steps, len, octave, degree, note;
    note_t res;
    den = (cur_span == 0) ? 64'sd1 : longint'(cur_span);
    diff = longint'(cur_center) - longint'(w);
    rad = longint'(cur_radius);
    steps = floor_quot(diff * 2 * rad, den);
    note = steps;
    if (cur_mode >= MODE_MAJOR && cur_mode <= MODE_BLUES) begin
      len = scale_size[cur_mode];
      octave = floor_quot(steps, len);
      degree = steps - octave * len;
      note = octave * 12 + scale_steps[cur_mode][degree];
    end
    res.clamp = 1'b0;
    if (note > SEMI_MAX) begin
      note = SEMI_MAX;
      res.clamp = 1'b1;
    end else if (note < SEMI_MIN) begin
      note = SEMI_MIN;
      res.clamp = 1'b1;
    end
    res.semi = note[SEMI_BITS-1:0];
    return res;
  endfunction

  // Widths cluster around the center so that most step counts stay in range.
  function automatic logic [W_BITS-1:0] pick_width();
    int spread, off, w;
    if ($urandom_range(0, 3) == 0) return W_BITS'($urandom);
    spread = (cur_span == 0) ? 64 : int'(cur_span);
    if ($urandom_range(0, 7) == 0) spread = 2;
    else if ($urandom_range(0, 4) == 0) spread = spread * 4;
    off = $urandom_range(0, spread);
    if ($urandom_range(0, 1) == 1) off = -off;
    w = int'(cur_center) + off;
    if (w < 0) w = 0;
    if (w > 65535) w = 65535;
    return W_BITS'(w);
  endfunction

  // Writes all four registers; spare upper data bits carry noise.
  task automatic load_config(mode_t m, logic [6:0] rad, logic [W_BITS-1:0] ctr,
                             logic [W_BITS-1:0] spn);
    cfg_index_t        regs  [4];
    logic [W_BITS-1:0] words [4];
    logic [W_BITS-1:0] junk;
    junk = W_BITS'($urandom);
    regs = '{REG_SCALE_MODE, REG_STEP_RADIUS, REG_WIDTH_CENTER, REG_WIDTH_SPAN};
    words = '{{junk[W_BITS-1:3], m}, {junk[W_BITS-1:7], rad}, ctr, spn};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= words[i];
      @(posedge clk);
    end
    cfg_wr_en  <= 1'b0;
    cur_mode   = m;
    cur_radius = rad;
    cur_center = ctr;
    cur_span   = spn;
  endtask

  // Offers one width and holds it until the transfer happens.
  task automatic offer_width(logic [W_BITS-1:0] w, note_t want);
    in_valid     <= 1'b1;
    stroke_width <= w;
    do @(posedge clk); while (!in_ready);
    expected_notes.push_back(want);
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (!sender_steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (expected_notes.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall pattern in segments, plus one long hold on request.
  initial begin
    int hold_left, run_left, style;
    bit nxt;
    hold_left = 0;
    run_left  = 0;
    style     = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        nxt = 1'b0;
      end else begin
        if (run_left == 0) begin
          style    = $urandom_range(0, 3);
          run_left = $urandom_range(8, 60);
        end
        run_left--;
        case (style)
          0: nxt = 1'b1;
          1: nxt = 1'($urandom_range(0, 1));
          2: nxt = ($urandom_range(0, 7) != 0);
          default: nxt = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready <= nxt;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    note_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_notes.size() == 0) begin
        $error("unexpected result: semitone %0d clamped %0b", semitone, clamped);
        mismatches++;
      end else begin
        want = expected_notes.pop_front();
        if (semitone !== want.semi) begin
          $error("semitone: expected %0d, got %0d", want.semi, semitone);
          mismatches++;
        end
        if (clamped !== want.clamp) begin
          $error("clamped: expected %0b, got %0b", want.clamp, clamped);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table, then random phases under varied settings.
  initial begin
    stim_row_t         row;
    mode_t             m;
    logic [6:0]        rad;
    logic [W_BITS-1:0] ctr, spn, w;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; settings change only once the pipeline is empty.
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.mode != cur_mode || row.radius != cur_radius ||
          row.center != cur_center || row.span != cur_span) begin
        in_valid <= 1'b0;
        wait_drained();
        load_config(row.mode, row.radius, row.center, row.span);
      end
      offer_width(row.width, row.known ? note_t'{row.semi, row.clamp} : quantize_width(row.width));
      pace_sender();
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random phases; the early ones sweep the register extremes.
    for (int p = 0; p < PHASES; p++) begin
      m = mode_t'(p % 8);
      if (p == 4) rad = 7'd0;
      else if (p == 2) rad = 7'd127;
      else if (p % 4 == 1) rad = 7'd64;
      else if (p % 4 == 3) rad = 7'd1;
      else rad = 7'($urandom_range(1, 64));
      if (p == 5) ctr = '0;
      else if (p == 6) ctr = '1;
      else ctr = W_BITS'($urandom);
      if (p == 7) spn = '0;
      else if (p == 8) spn = '1;
      else if (p == 9) spn = W_BITS'(1);
      else spn = W_BITS'($urandom_range(256, 65535));
      load_config(m, rad, ctr, spn);

      // One phase keeps offering while the receiver holds off, so the pipe backs up.
      if (p == 3) begin
        long_hold_req = 1'b1;
        sender_steady = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) begin
        w = pick_width();
        offer_width(w, quantize_width(w));
        pace_sender();
      end
      sender_steady = 1'b0;
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_notes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/wtssq_pkg.sv
src/width_to_scale_semitone_quantizer.sv
sim/tb_top.sv
